// ===== sv/lookup3_byte_hash_macros.svh =====
// ----------------------------------------------------------------------------
// lookup3 byte hash assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LOOKUP3_BYTE_HASH_MACROS_SVH
`define LOOKUP3_BYTE_HASH_MACROS_SVH

// implication checked at every rising edge outside reset
`define LU3BH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lookup3_byte_hash: implication check failed");

// condition that holds at every rising edge outside reset
`define LU3BH_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lookup3_byte_hash: invariant check failed");

`endif

// ===== sv/lu3bh_pkg.sv =====
// ----------------------------------------------------------------------------
// lu3bh_pkg
// Types, constants and round functions of the lookup3 byte hash.
// ----------------------------------------------------------------------------
package lu3bh_pkg;

  localparam logic [31:0] SEED_BASE  = 32'hdeadbeef;
  localparam logic [3:0]  BLOCK_LAST = 4'd11;

  // the three lookup3 working words
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  // mix unit result toward the byte front end
  typedef struct packed {
    logic   done;
    words_t w;
  } mix_res_t;

  // job handed to the final mixing pipe
  typedef struct packed {
    logic   raw;
    words_t w;
  } fin_job_t;

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // mix, rounds one and two
  function automatic words_t mix_12(words_t w);
    logic [31:0] a, b, c;
    words_t r;
    a = w.a; b = w.b; c = w.c;
    a = a - c; a = a ^ rotl(c, 4); c = c + b;
    b = b - a; b = b ^ rotl(a, 6); a = a + c;
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // mix, rounds three and four
  function automatic words_t mix_34(words_t w);
    logic [31:0] a, b, c;
    words_t r;
    a = w.a; b = w.b; c = w.c;
    c = c - b; c = c ^ rotl(b, 8);  b = b + a;
    a = a - c; a = a ^ rotl(c, 16); c = c + b;
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // mix, rounds five and six
  function automatic words_t mix_56(words_t w);
    logic [31:0] a, b, c;
    words_t r;
    a = w.a; b = w.b; c = w.c;
    b = b - a; b = b ^ rotl(a, 19); a = a + c;
    c = c - b; c = c ^ rotl(b, 4);  b = b + a;
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // final, rounds one to three
  function automatic words_t fin_123(words_t w);
    logic [31:0] a, b, c;
    words_t r;
    a = w.a; b = w.b; c = w.c;
    c = c ^ b; c = c - rotl(b, 14);
    a = a ^ c; a = a - rotl(c, 11);
    b = b ^ a; b = b - rotl(a, 25);
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // final, rounds four and five
  function automatic words_t fin_45(words_t w);
    logic [31:0] a, b, c;
    words_t r;
    a = w.a; b = w.b; c = w.c;
    c = c ^ b; c = c - rotl(b, 16);
    a = a ^ c; a = a - rotl(c, 4);
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // final, rounds six and seven, only c is needed
  function automatic logic [31:0] fin_67(words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    b = b ^ a; b = b - rotl(a, 14);
    c = c ^ b; c = c - rotl(b, 24);
    return c;
  endfunction

endpackage

// ===== sv/lookup3_byte_hash.sv =====
// ----------------------------------------------------------------------------
// lookup3_byte_hash
// Byte-serial lookup3 little-endian hash, initial value zero.
// ----------------------------------------------------------------------------
//  channel  dir  signals                     content
//  s_       in   tvalid tready tdata tlast   key byte, key length, last byte
//  m_       out  tvalid tready tdata         32-bit hash
//
//  One byte is taken per cycle while no key-ending item is held. A full block
//  starts the three-stage mix unit; a last byte arriving while that mix is
//  still in flight waits, since its block needs the mixed words.
//  The hash then passes the final pipe (f0, f1, f2) and the result register.
//  Output back pressure fills the elastic final pipe; only items that end a
//  key wait for room, other bytes keep flowing.
//  Reset is synchronous and clears the control state.
// ----------------------------------------------------------------------------
module lookup3_byte_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte[7:0], key_length[39:8]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // hash_value[31:0]
);
  import lu3bh_pkg::*;

  logic [7:0]  data_byte;
  logic [31:0] key_length;
  logic [31:0] seed;
  words_t      seed_w;

  logic        key_active;
  logic [3:0]  block_pos;
  words_t      base;
  logic [95:0] blk;

  logic [3:0]  pos;
  logic [95:0] blk_eff;
  logic [95:0] blk_next;
  words_t      base_eff;
  words_t      sum;
  logic        empty_key;
  logic        need_fin;
  logic        block_full;
  logic        take;
  logic        mix_launch;
  logic        mix_busy;
  mix_res_t    mix_res;
  logic        fin_ready;
  logic        fin_push;
  fin_job_t    fin_job;

  assign data_byte  = s_tdata[7:0];
  assign key_length = s_tdata[39:8];
  assign seed       = SEED_BASE + key_length;
  assign seed_w     = '{a: seed, b: seed, c: seed};

  // a new key starts from the seed and an empty block
  assign pos      = key_active ? block_pos : '0;
  assign blk_eff  = key_active ? blk : '0;
  assign base_eff = key_active ? base : seed_w;
  assign blk_next = blk_eff | ({88'd0, data_byte} << {pos, 3'b000});

  // block bytes added onto the words
  assign sum.a = base_eff.a + blk_next[31:0];
  assign sum.b = base_eff.b + blk_next[63:32];
  assign sum.c = base_eff.c + blk_next[95:64];

  assign empty_key  = !key_active && (key_length == '0);
  assign need_fin   = s_tlast || empty_key;
  assign block_full = (pos == BLOCK_LAST);

  // a key-ending item needs room in the final pipe and settled words
  assign s_tready   = !need_fin || (fin_ready && !(key_active && mix_busy));
  assign take       = s_tvalid && s_tready;
  assign mix_launch = take && !need_fin && block_full;
  assign fin_push   = take && need_fin;

  assign fin_job.raw = empty_key;
  assign fin_job.w   = empty_key ? seed_w : sum;

  // key and block tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      key_active <= 1'b0;
      block_pos  <= '0;
    end else if (take) begin
      if (need_fin) begin
        key_active <= 1'b0;
        block_pos  <= '0;
      end else begin
        key_active <= 1'b1;
        block_pos  <= block_full ? 4'd0 : pos + 4'd1;
      end
    end
  end

  // block bytes and base words
  always_ff @(posedge clk) begin
    if (take && !need_fin) begin
      blk <= block_full ? '0 : blk_next;
    end
    if (mix_res.done) begin
      base <= mix_res.w;
    end else if (take && !key_active) begin
      base <= seed_w;
    end
  end

  lu3bh_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .launch   (mix_launch),
    .launch_w (sum),
    .res      (mix_res),
    .busy     (mix_busy)
  );

  lu3bh_final u_final (
    .clk      (clk),
    .rst      (rst),
    .push     (fin_push),
    .job      (fin_job),
    .ready    (fin_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // checks
`include "lookup3_byte_hash_macros.svh"

  `LU3BH_ASSERT_IMP(a_mix_spacing, mix_launch, !mix_busy)
  `LU3BH_ASSERT_IMP(a_fin_settled, fin_push && key_active, !mix_busy)
  `LU3BH_ASSERT_ALWAYS(a_pos_range, block_pos <= BLOCK_LAST)
  `LU3BH_ASSERT_IMP(a_key_end, $fell(key_active), $past(rst) || $past(fin_push))

endmodule

// ===== sv/lu3bh_mix.sv =====
// ----------------------------------------------------------------------------
// lu3bh_mix
// Three-stage pipelined block mix; the result is taken combinationally from stage s2.
// ----------------------------------------------------------------------------
module lu3bh_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              launch,
  input  lu3bh_pkg::words_t launch_w,
  output lu3bh_pkg::mix_res_t res,
  output logic              busy
);
  import lu3bh_pkg::*;

  logic   [2:0] v;
  words_t       s0;
  words_t       s1;
  words_t       s2;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[1:0], launch};
    end
  end

  // stage payload; s0 holds the launch words, s1 and s2 each add two rounds
  always_ff @(posedge clk) begin
    s0 <= launch_w;
    s1 <= mix_12(s0);
    s2 <= mix_34(s1);
  end

  // last rounds feed the owner's base words directly
  assign res.done = v[2];
  assign res.w    = mix_56(s2);
  assign busy     = |v;

endmodule

// ===== sv/lu3bh_final.sv =====
// ----------------------------------------------------------------------------
// lu3bh_final
// Elastic final-mixing pipe ending in the result register.
// ----------------------------------------------------------------------------
module lu3bh_final (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lu3bh_pkg::fin_job_t job,
  output logic                ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata    // hash_value[31:0]
);
  import lu3bh_pkg::*;

  logic     f0_v, f1_v, f2_v;
  fin_job_t f0, f1, f2;
  logic     out_rdy, f2_rdy, f1_rdy;

  // each stage moves when the next one is empty or moving
  assign out_rdy = !m_tvalid || m_tready;
  assign f2_rdy  = !f2_v || out_rdy;
  assign f1_rdy  = !f1_v || f2_rdy;
  assign ready   = !f0_v || f1_rdy;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v     <= 1'b0;
      f1_v     <= 1'b0;
      f2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ready)   f0_v     <= push;
      if (f1_rdy)  f1_v     <= f0_v;
      if (f2_rdy)  f2_v     <= f1_v;
      if (out_rdy) m_tvalid <= f2_v;
    end
  end

  // stage payload; a raw job passes its c word untouched
  always_ff @(posedge clk) begin
    if (ready) begin
      f0 <= job;
    end
    if (f1_rdy) begin
      f1.raw <= f0.raw;
      f1.w   <= f0.raw ? f0.w : fin_123(f0.w);
    end
    if (f2_rdy) begin
      f2.raw <= f1.raw;
      f2.w   <= f1.raw ? f1.w : fin_45(f1.w);
    end
    if (out_rdy) begin
      m_tdata <= f2.raw ? f2.w.c : fin_67(f2.w);
    end
  end

endmodule
